// File: rtl/atrs_pkg.sv
// Package: payload types, command codes and constants of the shadow register block.
`timescale 1ns / 1ps
`default_nettype none
package atrs_pkg;

	localparam int MAX_MODULES_DEF = 8;
	localparam int SLOT_LIMIT      = 8;   // defined_mask has one bit per slot
	localparam int QUEUE_DEPTH     = 2;
	localparam int QPTR_W          = 1;
	localparam int QCNT_W          = 2;

	localparam logic [4:0] CMD_CTRL_FIRST = 5'd0;
	localparam logic [4:0] CMD_CTRL_LAST  = 5'd7;
	localparam logic [4:0] CMD_PILE_FIRST = 5'd8;
	localparam logic [4:0] CMD_PILE_LAST  = 5'd11;
	localparam logic [4:0] CMD_WIN_FIRST  = 5'd12;
	localparam logic [4:0] CMD_WIN_LAST   = 5'd17;
	localparam logic [4:0] CMD_STATUS     = 5'd18;

	localparam logic [2:0] REG_CONTROL = 3'd2;
	localparam logic [2:0] REG_DISC    = 3'd3;
	localparam logic [2:0] REG_PILEUP  = 3'd6;

	localparam logic KIND_WRITE = 1'b0;
	localparam logic KIND_REPLY = 1'b1;

	localparam logic [1:0] ST_OK          = 2'd0;
	localparam logic [1:0] ST_SELF_TEST   = 2'd1;
	localparam logic [1:0] ST_WAS_RESET   = 2'd2;
	localparam logic [1:0] ST_NO_RESPONSE = 2'd3;

	localparam logic [7:0] STAT_NONE_BYTE  = 8'hff;
	localparam int         STAT_RESET_BIT  = 3;   // 0x08
	localparam int         STAT_FAILED_BIT = 4;   // 0x10

	localparam logic [7:0] UPPER_LEVEL_BIT = 8'h20;

	// dac = p * 4095 / 10000, division by exact reciprocal 2^40 / 10000 rounded up
	localparam logic [13:0] PCT_FULL    = 14'd10000;
	localparam logic [26:0] RECIP_DAC   = 27'd109951163;
	localparam int          RECIP_SHIFT = 40;

	typedef enum logic [2:0] {
		CLS_ERR,
		CLS_CTRL,
		CLS_PILE,
		CLS_WIN,
		CLS_STAT,
		CLS_NOP
	} cls_t;

	typedef struct packed {
		logic [4:0]         cmd;
		logic [7:0]         module_index;
		logic               flag_value;
		logic signed [15:0] percent_hundredths;
		logic [7:0]         read_byte;
	} req_t;

	typedef struct packed {
		logic       kind;
		logic [7:0] target_module;
		logic [2:0] reg_offset;
		logic [1:0] byte_count;
		logic [7:0] data_low;
		logic [7:0] data_high;
		logic       error_flag;
		logic [1:0] status_code;
		logic       last;
	} rsp_t;

	typedef struct packed {
		cls_t       cls;
		logic [2:0] sel;
		logic [7:0] module_index;
		logic       flag_value;
		logic [11:0] dac;
		logic [1:0] status_code;
		logic       status_err;
	} entry_t;

	function automatic logic [7:0] ctrl_mask(input logic [2:0] sel);
		logic [7:0] m;
		unique case (sel)
			3'd0: m = 8'h01;
			3'd1: m = 8'h04;
			3'd2: m = 8'h08;
			3'd3: m = 8'h10;
			3'd4: m = 8'h20;
			3'd5: m = 8'h40;
			3'd6: m = 8'h80;
			default: m = 8'h02;
		endcase
		return m;
	endfunction

	function automatic logic [7:0] chan_bits(input logic [1:0] ch);
		logic [7:0] b;
		unique case (ch)
			2'd1: b = 8'h40;
			2'd2: b = 8'h80;
			default: b = 8'h00;
		endcase
		return b;
	endfunction

endpackage
`default_nettype wire

// File: rtl/atrs_front.sv
// Front end: accepts requests, checks the slot, decodes the command and scales window levels.
`timescale 1ns / 1ps
`default_nettype none
module atrs_front import atrs_pkg::*; #(
	parameter int MAX_MODULES = MAX_MODULES_DEF
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       req_valid,
	output logic            req_stall,
	input  wire req_t       req,
	input  wire logic [7:0] defined_mask,
	output logic            push_valid,
	input  wire logic       push_ready,
	output entry_t          push_data
);

	logic        valid_s1;
	entry_t      entry_s1;
	logic [25:0] scaled_s1;

	entry_t      entry_n;
	logic        bad;
	logic [13:0] pct;
	logic [52:0] prod;
	logic        load;

	assign load      = !valid_s1 || push_ready;
	assign req_stall = !load;

	always_comb begin
		bad = (32'(req.module_index) >= MAX_MODULES)
			|| (req.module_index >= 8'(SLOT_LIMIT))
			|| !defined_mask[req.module_index[2:0]];

		entry_n              = '0;
		entry_n.module_index = req.module_index;
		entry_n.flag_value   = req.flag_value;
		entry_n.cls          = CLS_NOP;
		case (req.cmd) inside
			[CMD_CTRL_FIRST:CMD_CTRL_LAST]: begin
				entry_n.cls = CLS_CTRL;
				entry_n.sel = 3'(req.cmd - CMD_CTRL_FIRST);
			end
			[CMD_PILE_FIRST:CMD_PILE_LAST]: begin
				entry_n.cls = CLS_PILE;
				entry_n.sel = 3'(req.cmd - CMD_PILE_FIRST);
			end
			[CMD_WIN_FIRST:CMD_WIN_LAST]: begin
				entry_n.cls = CLS_WIN;
				entry_n.sel = 3'(req.cmd - CMD_WIN_FIRST);
			end
			CMD_STATUS: begin
				entry_n.cls = CLS_STAT;
				if (req.read_byte == STAT_NONE_BYTE) begin
					entry_n.status_code = ST_NO_RESPONSE;
					entry_n.status_err  = 1'b1;
				end else if (req.read_byte[STAT_RESET_BIT]) begin
					entry_n.status_code = ST_WAS_RESET;
				end else if (req.read_byte[STAT_FAILED_BIT]) begin
					entry_n.status_code = ST_SELF_TEST;
				end else begin
					entry_n.status_code = ST_OK;
				end
			end
			default: entry_n.cls = CLS_NOP;
		endcase
		if (bad) begin
			entry_n.cls = CLS_ERR;
		end

		if (req.percent_hundredths[15]) begin
			pct = '0;
		end else if (req.percent_hundredths > 16'sd10000) begin
			pct = PCT_FULL;
		end else begin
			pct = req.percent_hundredths[13:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load) begin
			valid_s1 <= req_valid;
		end
	end

	// p * 4095 as shift and subtract
	always_ff @(posedge clk) begin
		if (load && req_valid) begin
			entry_s1  <= entry_n;
			scaled_s1 <= {pct, 12'b0} - 26'(pct);
		end
	end

	assign prod = 53'(scaled_s1) * 53'(RECIP_DAC);

	always_comb begin
		push_data     = entry_s1;
		push_data.dac = prod[RECIP_SHIFT +: 12];
	end

	assign push_valid = valid_s1;

endmodule
`default_nettype wire

// File: rtl/atrs_queue.sv
// Short queue of decoded commands between front end and back end.
`timescale 1ns / 1ps
`default_nettype none
module atrs_queue import atrs_pkg::*; (
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   push_valid,
	output logic        push_ready,
	input  wire entry_t push_data,
	output logic        head_valid,
	input  wire logic   pop,
	output entry_t      head
);

	entry_t              entries_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q;
	logic [QPTR_W-1:0]   rd_ptr_q;
	logic [QCNT_W-1:0]   count_q;
	logic                do_push;
	logic                do_pop;

	assign push_ready = count_q != QCNT_W'(QUEUE_DEPTH);
	assign head_valid = count_q != '0;
	assign head       = entries_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			entries_q[wr_ptr_q] <= push_data;
		end
	end

endmodule
`default_nettype wire

// File: rtl/atrs_back.sv
// Back end: shadow settings, response sequencing and output register.
`timescale 1ns / 1ps
`default_nettype none
module atrs_back import atrs_pkg::*; #(
	parameter int MAX_MODULES = MAX_MODULES_DEF
) (
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   head_valid,
	input  wire entry_t head,
	output logic        pop,
	output logic        rsp_valid,
	input  wire logic   rsp_stall,
	output rsp_t        rsp
);

	localparam int SLOTS  = (MAX_MODULES < SLOT_LIMIT) ? MAX_MODULES : SLOT_LIMIT;
	localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int LVLS   = SLOTS * 3;
	localparam int LVL_W  = $clog2(LVLS);

	logic [7:0]  ctrl_q  [SLOTS];
	logic [3:0]  pile_q  [SLOTS];
	logic [11:0] lower_q [LVLS];
	logic [11:0] upper_q [LVLS];
	logic [1:0]  step_q;
	logic        rsp_valid_q;
	rsp_t        rsp_q;

	logic [SLOT_W-1:0] slot;
	logic [1:0]        ch;
	logic [4:0]        lvl_full;
	logic [LVL_W-1:0]  lidx;
	logic [7:0]        ctrl_new;
	logic [3:0]        pile_new;
	logic [11:0]       lo_cur;
	logic [11:0]       hi_cur;
	logic              adv;
	logic              done;
	logic              first;
	rsp_t              rsp_n;

	assign slot     = head.module_index[SLOT_W-1:0];
	assign ch       = head.sel[2:1];
	assign lvl_full = 5'(head.module_index[2:0]) * 5'd3 + 5'(ch);
	assign lidx     = lvl_full[LVL_W-1:0];
	assign adv      = head_valid && (!rsp_valid_q || !rsp_stall);
	assign first    = step_q == 2'd0;

	assign ctrl_new = head.flag_value ? (ctrl_q[slot] | ctrl_mask(head.sel))
	                                  : (ctrl_q[slot] & ~ctrl_mask(head.sel));
	assign pile_new = head.flag_value ? (pile_q[slot] | (4'b0001 << head.sel[1:0]))
	                                  : (pile_q[slot] & ~(4'b0001 << head.sel[1:0]));
	assign lo_cur   = (first && !head.sel[0]) ? head.dac : lower_q[lidx];
	assign hi_cur   = upper_q[lidx];

	always_comb begin
		rsp_n               = '0;
		rsp_n.kind          = KIND_REPLY;
		rsp_n.target_module = head.module_index;
		rsp_n.last          = 1'b1;
		done                = 1'b1;
		case (head.cls)
			CLS_ERR:  rsp_n.error_flag = 1'b1;
			CLS_STAT: begin
				rsp_n.error_flag  = head.status_err;
				rsp_n.status_code = head.status_code;
			end
			CLS_CTRL: if (first) begin
				rsp_n            = '0;
				rsp_n.kind       = KIND_WRITE;
				rsp_n.target_module = head.module_index;
				rsp_n.reg_offset = REG_CONTROL;
				rsp_n.byte_count = 2'd1;
				rsp_n.data_low   = ctrl_new;
				done             = 1'b0;
			end
			CLS_PILE: if (first) begin
				rsp_n            = '0;
				rsp_n.kind       = KIND_WRITE;
				rsp_n.target_module = head.module_index;
				rsp_n.reg_offset = REG_PILEUP;
				rsp_n.byte_count = 2'd1;
				rsp_n.data_low   = {4'b0, pile_new};
				done             = 1'b0;
			end
			CLS_WIN: if (step_q != 2'd2) begin
				rsp_n            = '0;
				rsp_n.kind       = KIND_WRITE;
				rsp_n.target_module = head.module_index;
				rsp_n.reg_offset = REG_DISC;
				rsp_n.byte_count = 2'd2;
				if (first) begin
					rsp_n.data_low  = lo_cur[7:0];
					rsp_n.data_high = {4'b0, lo_cur[11:8]} | chan_bits(ch);
				end else begin
					rsp_n.data_low  = hi_cur[7:0];
					rsp_n.data_high = {4'b0, hi_cur[11:8]} | chan_bits(ch) | UPPER_LEVEL_BIT;
				end
				done = 1'b0;
			end
			default: ;
		endcase
	end

	assign pop = adv && done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q      <= '0;
			rsp_valid_q <= 1'b0;
			for (int i = 0; i < SLOTS; i++) begin
				ctrl_q[i] <= '0;
				pile_q[i] <= '0;
			end
			for (int i = 0; i < LVLS; i++) begin
				lower_q[i] <= '0;
				upper_q[i] <= '0;
			end
		end else begin
			if (adv) begin
				rsp_valid_q <= 1'b1;
				step_q      <= done ? 2'd0 : step_q + 2'd1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			if (adv && first) begin
				case (head.cls)
					CLS_CTRL: ctrl_q[slot] <= ctrl_new;
					CLS_PILE: pile_q[slot] <= pile_new;
					CLS_WIN: begin
						if (head.sel[0]) begin
							upper_q[lidx] <= head.dac;
						end else begin
							lower_q[lidx] <= head.dac;
						end
					end
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rsp_q <= rsp_n;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	a_step_win: assert property (@(posedge clk) disable iff (!arst_n)
		step_q == 2'd2 |-> head_valid && head.cls == CLS_WIN)
		else $error("third step outside a window command");

	a_pop_reply: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> rsp_valid_q && rsp_q.kind == KIND_REPLY && rsp_q.last)
		else $error("command retired without its reply");

	a_write_clean: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && rsp_q.kind == KIND_WRITE |-> !rsp_q.error_flag && !rsp_q.last)
		else $error("bus write flagged as error or last");

	a_step_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(step_q))
		else $error("sequencer step moved without output advance");

endmodule
`default_nettype wire

// File: rtl/amp_tca_register_shadow.sv
// Top level: shadow settings for timing/amplifier modules, turning commands into bus writes.
//
// Usage: requests enter on req (req_valid / req_stall), responses leave on rsp
// (rsp_valid / rsp_stall); an item moves when valid is high and stall is low.
// The defined_mask register is written on cfg (cfg_valid / cfg_ready, always
// ready); the user must write it only while the block is idle, and the block
// itself does not enforce this. Each request yields one to three responses: bus
// writes first, then one reply with last set. A request is registered in the
// front stage, then written into the queue, and its first response is then held
// in the output register. The back end sequencer emits one response per cycle
// unless the receiver stalls; a request holds it for one (error, status,
// invalid), two (flag) or three (window) responses, and it sets the sustained rate.
// The front end keeps accepting into a two-entry queue while the back end or
// the receiver is stalled; req_stall rises only once the queue and front stage
// are full. A stalled response holds in the output register.
// Reset clears all shadow settings to zero, the mask, the queue and the output.
`timescale 1ns / 1ps
`default_nettype none
module amp_tca_register_shadow import atrs_pkg::*; #(
	parameter int MAX_MODULES = MAX_MODULES_DEF
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       req_valid,
	output logic            req_stall,
	input  wire req_t       req,
	output logic            rsp_valid,
	input  wire logic       rsp_stall,
	output rsp_t            rsp,
	input  wire logic       cfg_valid,
	output logic            cfg_ready,
	input  wire logic [7:0] cfg_data
);

	logic [7:0] defined_mask_q;
	logic       push_valid;
	logic       push_ready;
	entry_t     push_data;
	logic       head_valid;
	logic       pop;
	entry_t     head;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			defined_mask_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			defined_mask_q <= cfg_data;
		end
	end

	atrs_front #(.MAX_MODULES(MAX_MODULES)) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.req_valid    (req_valid),
		.req_stall    (req_stall),
		.req          (req),
		.defined_mask (defined_mask_q),
		.push_valid   (push_valid),
		.push_ready   (push_ready),
		.push_data    (push_data)
	);

	atrs_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data),
		.head_valid (head_valid),
		.pop        (pop),
		.head       (head)
	);

	atrs_back #(.MAX_MODULES(MAX_MODULES)) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop),
		.rsp_valid  (rsp_valid),
		.rsp_stall  (rsp_stall),
		.rsp        (rsp)
	);

endmodule
`default_nettype wire

// File: bench/atrs_checker.sv
// Checker: predicts the bus writes and replies of the shadow register block and compares them.
`timescale 1ns / 1ps
module shadow_write_checker import atrs_pkg::*; #(
	parameter int MAX_MODULES = MAX_MODULES_DEF
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       req_valid,
	input  wire logic       req_stall,
	input  wire req_t       req,
	input  wire logic       rsp_valid,
	input  wire logic       rsp_stall,
	input  wire rsp_t       rsp,
	input  wire logic       cfg_valid,
	input  wire logic       cfg_ready,
	input  wire logic [7:0] cfg_data,
	output int              fail_count,
	output int              outstanding,
	output int              matched_count
);

	localparam logic [7:0] CH2_BITS = 8'h40;
	localparam logic [7:0] CH3_BITS = 8'h80;
	localparam int         PCT_MAX  = 10000;
	localparam int         DAC_FULL = 4095;

	logic [7:0]  module_mask;
	logic [7:0]  ctrl_shadow [MAX_MODULES];
	logic [3:0]  pile_shadow [MAX_MODULES];
	logic [11:0] lower_dac [MAX_MODULES*3];
	logic [11:0] upper_dac [MAX_MODULES*3];
	rsp_t        pending_writes [$];
	int          fails;
	int          matched;

	function automatic logic [11:0] level_to_dac(input logic signed [15:0] pct);
		int p;
		p = pct;
		if (p < 0)
			p = 0;
		else if (p > PCT_MAX)
			p = PCT_MAX;
		return 12'((p * DAC_FULL) / PCT_MAX);
	endfunction

	function automatic logic [7:0] ctrl_bit(input logic [2:0] sel);
		case (sel)
			3'd0: return 8'h01;
			3'd1: return 8'h04;
			3'd2: return 8'h08;
			3'd3: return 8'h10;
			3'd4: return 8'h20;
			3'd5: return 8'h40;
			3'd6: return 8'h80;
			default: return 8'h02;
		endcase
	endfunction

	function automatic rsp_t bus_write(input logic [7:0] mi, input logic [2:0] regno,
		input logic [1:0] cnt, input logic [7:0] lo, input logic [7:0] hi);
		rsp_t w;
		w = '0;
		w.kind = KIND_WRITE;
		w.target_module = mi;
		w.reg_offset = regno;
		w.byte_count = cnt;
		w.data_low = lo;
		w.data_high = hi;
		return w;
	endfunction

	task automatic predict_bus_writes(input req_t r);
		rsp_t        reply;
		logic [7:0]  mi;
		logic [7:0]  m;
		logic [7:0]  chb;
		logic [11:0] d;
		int          off;
		int          ch;
		int          slot;
		mi = r.module_index;
		reply = '0;
		reply.kind = KIND_REPLY;
		reply.target_module = mi;
		reply.last = 1'b1;
		if (mi >= MAX_MODULES || mi >= 8 || !module_mask[mi[2:0]]) begin
			reply.error_flag = 1'b1;
			pending_writes.push_back(reply);
			return;
		end
		if (r.cmd <= CMD_CTRL_LAST) begin
			m = ctrl_bit(r.cmd[2:0]);
			ctrl_shadow[mi] = r.flag_value ? (ctrl_shadow[mi] | m) : (ctrl_shadow[mi] & ~m);
			pending_writes.push_back(bus_write(mi, REG_CONTROL, 2'd1, ctrl_shadow[mi], 8'h00));
		end else if (r.cmd <= CMD_PILE_LAST) begin
			m = 8'h01 << (r.cmd - CMD_PILE_FIRST);
			pile_shadow[mi] = r.flag_value ? (pile_shadow[mi] | m[3:0])
				: (pile_shadow[mi] & ~m[3:0]);
			pending_writes.push_back(bus_write(mi, REG_PILEUP, 2'd1, {4'h0, pile_shadow[mi]},
				8'h00));
		end else if (r.cmd <= CMD_WIN_LAST) begin
			off = r.cmd - CMD_WIN_FIRST;
			ch = off >> 1;
			slot = mi * 3 + ch;
			d = level_to_dac(r.percent_hundredths);
			if (off & 1)
				upper_dac[slot] = d;
			else
				lower_dac[slot] = d;
			chb = (ch == 0) ? 8'h00 : (ch == 1) ? CH2_BITS : CH3_BITS;
			pending_writes.push_back(bus_write(mi, REG_DISC, 2'd2, lower_dac[slot][7:0],
				{4'h0, lower_dac[slot][11:8]} | chb));
			pending_writes.push_back(bus_write(mi, REG_DISC, 2'd2, upper_dac[slot][7:0],
				{4'h0, upper_dac[slot][11:8]} | chb | UPPER_LEVEL_BIT));
		end else if (r.cmd == CMD_STATUS) begin
			if (r.read_byte == STAT_NONE_BYTE) begin
				reply.status_code = ST_NO_RESPONSE;
				reply.error_flag = 1'b1;
			end else if (r.read_byte[STAT_RESET_BIT]) begin
				reply.status_code = ST_WAS_RESET;
			end else if (r.read_byte[STAT_FAILED_BIT]) begin
				reply.status_code = ST_SELF_TEST;
			end else begin
				reply.status_code = ST_OK;
			end
		end
		pending_writes.push_back(reply);
	endtask

	task automatic check_field(input string name, input int want, input int got);
		if (want != got) begin
			fails++;
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
		end
	endtask

	task automatic check_response(input rsp_t got);
		rsp_t want;
		if (pending_writes.size() == 0) begin
			fails++;
			$display("%0t: unexpected response, expected none, got %h", $time, got);
			return;
		end
		want = pending_writes.pop_front();
		check_field("kind", want.kind, got.kind);
		check_field("target_module", want.target_module, got.target_module);
		check_field("reg_offset", want.reg_offset, got.reg_offset);
		check_field("byte_count", want.byte_count, got.byte_count);
		check_field("data_low", want.data_low, got.data_low);
		check_field("data_high", want.data_high, got.data_high);
		check_field("error_flag", want.error_flag, got.error_flag);
		check_field("status_code", want.status_code, got.status_code);
		check_field("last", want.last, got.last);
		matched++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			module_mask = '0;
			foreach (ctrl_shadow[i]) ctrl_shadow[i] = '0;
			foreach (pile_shadow[i]) pile_shadow[i] = '0;
			foreach (lower_dac[i]) lower_dac[i] = '0;
			foreach (upper_dac[i]) upper_dac[i] = '0;
			pending_writes.delete();
		end else begin
			if (rsp_valid && !rsp_stall)
				check_response(rsp);
			if (cfg_valid && cfg_ready)
				module_mask = cfg_data;
			if (req_valid && !req_stall)
				predict_bus_writes(req);
		end
		outstanding <= pending_writes.size();
		fail_count <= fails;
		matched_count <= matched;
	end

endmodule

// File: bench/tb_top.sv
// Testbench top: clock, reset, mask writes and command stimulus for the shadow register block.
`timescale 1ns / 1ps
module tb_top import atrs_pkg::*;;

	localparam int LIMIT = 300000;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       req_valid = 1'b0;
	logic       req_stall;
	req_t       req = '0;
	logic       rsp_valid;
	logic       rsp_stall = 1'b0;
	rsp_t       rsp;
	logic       cfg_valid = 1'b0;
	logic       cfg_ready;
	logic [7:0] cfg_data = '0;

	int fail_count;
	int outstanding;
	int matched_count;
	int cycles = 0;
	int sent = 0;
	int masks = 0;
	bit calm = 1'b0;

	amp_tca_register_shadow dut (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_stall(req_stall), .req(req),
		.rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	shadow_write_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_stall(req_stall), .req(req),
		.rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.fail_count(fail_count), .outstanding(outstanding), .matched_count(matched_count)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		rsp_stall <= !calm && ($urandom_range(99) < 32);
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	function automatic req_t mk(input logic [4:0] cmd, input logic [7:0] mi, input logic flag,
		input logic [15:0] pct, input logic [7:0] rb);
		req_t r;
		r.cmd = cmd;
		r.module_index = mi;
		r.flag_value = flag;
		r.percent_hundredths = pct;
		r.read_byte = rb;
		return r;
	endfunction

	function automatic req_t rand_req();
		req_t r;
		int   pick;
		if ($urandom_range(99) < 88)
			r.cmd = 5'($urandom_range(CMD_STATUS));
		else
			r.cmd = 5'($urandom_range(31, CMD_STATUS + 1));
		if ($urandom_range(99) < 85)
			r.module_index = 8'($urandom_range(MAX_MODULES_DEF - 1));
		else
			r.module_index = 8'($urandom);
		r.flag_value = 1'($urandom);
		pick = $urandom_range(99);
		if (pick < 45)
			r.percent_hundredths = 16'($urandom_range(10000));
		else if (pick < 60)
			r.percent_hundredths = 16'($urandom_range(10010, 9990));
		else if (pick < 70)
			r.percent_hundredths = 16'($urandom_range(4) - 2);
		else
			r.percent_hundredths = 16'($urandom);
		r.read_byte = ($urandom_range(99) < 15) ? STAT_NONE_BYTE : 8'($urandom);
		return r;
	endfunction

	// valid stays high across back-to-back commands; it drops only for an idle gap
	task automatic push_cmd(input req_t r);
		while (!calm && $urandom_range(99) < 32) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req <= r;
		@(posedge clk);
		while (req_stall) @(posedge clk);
		sent++;
	endtask

	task automatic drain();
		req_valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
	endtask

	task automatic write_mask(input logic [7:0] value);
		drain();
		repeat (4) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		masks++;
	endtask

	logic [7:0] phase_mask [7] = '{8'hff, 8'h00, 8'h00, 8'h01, 8'h80, 8'h00, 8'hff};
	int         phase_len [7] = '{120, 20, 100, 40, 40, 80, 60};

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// slot 6 left undefined for the directed part
		write_mask(8'hbf);
		push_cmd(mk(CMD_CTRL_FIRST, 8'd0, 1'b1, 16'h0000, 8'h00));
		push_cmd(mk(CMD_CTRL_LAST, 8'd7, 1'b1, 16'hffff, 8'hff));
		push_cmd(mk(CMD_CTRL_FIRST + 5'd3, 8'd0, 1'b0, 16'h1234, 8'h5a));
		push_cmd(mk(CMD_PILE_FIRST, 8'd1, 1'b1, 16'h0000, 8'h00));
		push_cmd(mk(CMD_PILE_LAST, 8'd1, 1'b1, 16'h7fff, 8'hff));
		push_cmd(mk(CMD_PILE_FIRST, 8'd1, 1'b0, 16'h8000, 8'h00));
		push_cmd(mk(CMD_WIN_FIRST, 8'd2, 1'b0, 16'd0, 8'h00));
		push_cmd(mk(CMD_WIN_FIRST + 5'd1, 8'd2, 1'b1, 16'd10000, 8'h00));
		push_cmd(mk(CMD_WIN_FIRST + 5'd2, 8'd3, 1'b0, 16'h7fff, 8'h00));
		push_cmd(mk(CMD_WIN_FIRST + 5'd3, 8'd3, 1'b1, 16'h8000, 8'h00));
		push_cmd(mk(CMD_WIN_FIRST + 5'd4, 8'd4, 1'b0, 16'd10001, 8'h00));
		push_cmd(mk(CMD_WIN_LAST, 8'd4, 1'b1, 16'hffff, 8'h00));
		push_cmd(mk(CMD_WIN_LAST, 8'd5, 1'b0, 16'd5000, 8'h00));
		push_cmd(mk(CMD_STATUS, 8'd0, 1'b0, 16'h0000, STAT_NONE_BYTE));
		push_cmd(mk(CMD_STATUS, 8'd1, 1'b0, 16'h0000, 8'h08));
		push_cmd(mk(CMD_STATUS, 8'd2, 1'b0, 16'h0000, 8'h18));
		push_cmd(mk(CMD_STATUS, 8'd3, 1'b0, 16'h0000, 8'h10));
		push_cmd(mk(CMD_STATUS, 8'd4, 1'b0, 16'h0000, 8'h00));
		push_cmd(mk(CMD_STATUS, 8'd5, 1'b0, 16'h0000, 8'he7));
		push_cmd(mk(CMD_STATUS + 5'd1, 8'd0, 1'b1, 16'h0000, 8'h00));
		push_cmd(mk(5'd31, 8'd7, 1'b1, 16'hffff, 8'hff));
		push_cmd(mk(CMD_CTRL_FIRST, 8'd8, 1'b1, 16'h0000, 8'h00));
		push_cmd(mk(CMD_STATUS, 8'd255, 1'b1, 16'h0000, STAT_NONE_BYTE));
		push_cmd(mk(CMD_CTRL_FIRST, 8'd6, 1'b1, 16'h0000, 8'h00));
		push_cmd(mk(CMD_WIN_FIRST, 8'd6, 1'b1, 16'd5000, 8'h00));

		for (int ph = 0; ph < 7; ph++) begin
			write_mask((ph == 2 || ph == 5) ? 8'($urandom) : phase_mask[ph]);
			calm = (ph == 2);
			for (int i = 0; i < phase_len[ph]; i++) begin
				if (ph == 0 && i == 60)
					drain();
				push_cmd(rand_req());
			end
			calm = 1'b0;
		end

		drain();
		repeat (20) @(posedge clk);
		$display("Sent %0d commands over %0d mask settings; %0d responses checked.",
			sent, masks, matched_count);
		$display("Covered flag, pile-up, window and status commands, bad and undefined slots.");
		if (fail_count == 0 && outstanding == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
